// ----- rtl/chb_pkg.sv -----
// Shared constants and types for the cubic Hermite basis evaluator.
`timescale 1ns / 1ps
`default_nettype none
package chb_pkg;

  typedef logic [1:0] basis_idx_t;
  typedef logic [0:0] cfg_idx_t;

  typedef enum logic [0:0] {
    CFG_START = 1'b0,
    CFG_END   = 1'b1
  } cfg_reg_e;

  localparam basis_idx_t LAST_BASIS = 2'd3;

  localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMIN = 32'sh8000_0000;

  // Power-basis coefficients on (1, t, t^2, t^3): [basis][derivative order in t][power].
  localparam logic signed [4:0] COEF [4][4][4] = '{
    '{'{5'sd1, 5'sd0, -5'sd3, 5'sd2}, '{5'sd0, -5'sd6, 5'sd6, 5'sd0},
      '{-5'sd6, 5'sd12, 5'sd0, 5'sd0}, '{5'sd12, 5'sd0, 5'sd0, 5'sd0}},
    '{'{5'sd0, 5'sd0, 5'sd3, -5'sd2}, '{5'sd0, 5'sd6, -5'sd6, 5'sd0},
      '{5'sd6, -5'sd12, 5'sd0, 5'sd0}, '{-5'sd12, 5'sd0, 5'sd0, 5'sd0}},
    '{'{5'sd0, 5'sd1, -5'sd2, 5'sd1}, '{5'sd1, -5'sd4, 5'sd3, 5'sd0},
      '{-5'sd4, 5'sd6, 5'sd0, 5'sd0}, '{5'sd6, 5'sd0, 5'sd0, 5'sd0}},
    '{'{5'sd0, 5'sd0, -5'sd1, 5'sd1}, '{5'sd0, -5'sd2, 5'sd3, 5'sd0},
      '{-5'sd2, 5'sd6, 5'sd0, 5'sd0}, '{5'sd6, 5'sd0, 5'sd0, 5'sd0}}
  };

endpackage
`default_nettype wire

// ----- rtl/chb_mul.sv -----
// Two-stage rounding fixed-point multiplier with saturation and bypass.
`timescale 1ns / 1ps
`default_nettype none
module chb_mul #(
  parameter int FRAC_BITS = 16,
  parameter int YW        = 32,
  parameter int PW        = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [31:0]   x_i,
  input  logic signed [YW-1:0] y_i,
  input  logic                 byp_i,
  input  logic [PW-1:0]        pay_i,
  output logic                 valid_o,
  output logic signed [31:0]   res_o,
  output logic                 flag_o,
  output logic [PW-1:0]        pay_o
);
  import chb_pkg::*;

  localparam int PWD = 32 + YW;
  localparam int RW  = PWD + 1 - FRAC_BITS;

  logic [31:0]    xm;
  logic [YW-1:0]  ym;
  logic [PWD-1:0] prod_q;
  logic           neg_q, byp_q, vld_q;
  logic [31:0]    x_q;
  logic [PW-1:0]  pay1_q;
  logic [PWD:0]   sum;
  logic [RW-1:0]  rm;
  logic signed [31:0] res_d;
  logic           flag_d;
  logic           vld_o_q;
  logic signed [31:0] res_q;
  logic           flag_q;
  logic [PW-1:0]  pay2_q;

  assign xm = x_i[31] ? (~x_i + 32'd1) : x_i;
  assign ym = y_i[YW-1] ? (~y_i + {{(YW-1){1'b0}}, 1'b1}) : y_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PWD'(xm) * PWD'(ym);
      neg_q  <= x_i[31] ^ y_i[YW-1];
      byp_q  <= byp_i;
      x_q    <= x_i;
      pay1_q <= pay_i;
    end
  end

  // Round half away from zero on the magnitude, then saturate.
  always_comb begin
    sum    = {1'b0, prod_q} + ((PWD + 1)'(1) << (FRAC_BITS - 1));
    rm     = sum[PWD:FRAC_BITS];
    flag_d = 1'b0;
    if (byp_q) begin
      res_d = x_q;
    end else if (!neg_q) begin
      if (rm > RW'(33'h0_7FFF_FFFF)) begin
        res_d  = QMAX;
        flag_d = 1'b1;
      end else begin
        res_d = rm[31:0];
      end
    end else begin
      if (rm > RW'(33'h0_8000_0000)) begin
        res_d  = QMIN;
        flag_d = 1'b1;
      end else begin
        res_d = ~rm[31:0] + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o_q <= 1'b0;
    end else if (en_i) begin
      vld_o_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q  <= res_d;
      flag_q <= flag_d;
      pay2_q <= pay1_q;
    end
  end

  assign valid_o = vld_o_q;
  assign res_o   = res_q;
  assign flag_o  = flag_q;
  assign pay_o   = pay2_q;

endmodule
`default_nettype wire

// ----- rtl/chb_div.sv -----
// Pipelined restoring divider: round(x * 2^F / h), one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module chb_div #(
  parameter int FRAC_BITS = 16,
  parameter int XW        = 32,
  parameter int PW        = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [XW-1:0] x_i,
  input  logic                 byp_i,
  input  logic [32:0]          den_i,
  input  logic                 den_neg_i,
  input  logic [PW-1:0]        pay_i,
  output logic                 valid_o,
  output logic signed [31:0]   res_o,
  output logic                 flag_o,
  output logic [PW-1:0]        pay_o
);
  import chb_pkg::*;

  localparam int QB = 33;
  localparam int DW = 33;
  localparam int NW = XW + FRAC_BITS + 1;

  logic [XW-1:0] mag;
  logic [NW-1:0] n_d;
  logic [NW-1:0] n_q;
  logic          neg_q, byp_q, vld_q;
  logic [31:0]   x_q;
  logic [PW-1:0] pay_q;
  logic [NW-1:0] hi;

  logic [DW-1:0] rem_s [0:QB];
  logic [QB-1:0] quo_s [0:QB];
  logic [QB-1:0] nlo_s [0:QB];
  logic          ovf_s [0:QB];
  logic          neg_s [0:QB];
  logic          byp_s [0:QB];
  logic [31:0]   x_s   [0:QB];
  logic [PW-1:0] pay_s [0:QB];
  logic          vld_s [0:QB];

  logic signed [31:0] res_d;
  logic               flag_d;
  logic [QB-1:0]      quo;
  logic               vld_o_q;
  logic signed [31:0] res_q;
  logic               flag_q;
  logic [PW-1:0]      pay_o_q;

  // Numerator magnitude plus half the divisor, so truncation rounds to nearest.
  assign mag = x_i[XW-1] ? (~x_i + {{(XW-1){1'b0}}, 1'b1}) : x_i;
  assign n_d = {1'b0, mag, {FRAC_BITS{1'b0}}} + NW'(den_i[DW-1:1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q   <= n_d;
      neg_q <= x_i[XW-1] ^ den_neg_i;
      byp_q <= byp_i;
      x_q   <= x_i[31:0];
      pay_q <= pay_i;
    end
  end

  // Quotient bits above the 33 kept ones mean the result saturates.
  assign hi = n_q >> QB;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s[0] <= 1'b0;
    end else if (en_i) begin
      vld_s[0] <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_s[0] <= hi[DW-1:0];
      quo_s[0] <= '0;
      nlo_s[0] <= n_q[QB-1:0];
      ovf_s[0] <= (hi >= NW'(den_i));
      neg_s[0] <= neg_q;
      byp_s[0] <= byp_q;
      x_s[0]   <= x_q;
      pay_s[0] <= pay_q;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_bit
    logic [DW:0] trial;
    logic        ge;
    logic [DW:0] diff;

    assign trial = {rem_s[j], nlo_s[j][QB-1]};
    assign ge    = (trial >= {1'b0, den_i});
    assign diff  = trial - {1'b0, den_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[j+1] <= 1'b0;
      end else if (en_i) begin
        vld_s[j+1] <= vld_s[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_s[j+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        quo_s[j+1] <= {quo_s[j][QB-2:0], ge};
        nlo_s[j+1] <= {nlo_s[j][QB-2:0], 1'b0};
        ovf_s[j+1] <= ovf_s[j];
        neg_s[j+1] <= neg_s[j];
        byp_s[j+1] <= byp_s[j];
        x_s[j+1]   <= x_s[j];
        pay_s[j+1] <= pay_s[j];
      end
    end
  end

  assign quo = quo_s[QB];

  always_comb begin
    flag_d = 1'b0;
    if (byp_s[QB]) begin
      res_d = x_s[QB];
    end else if (den_i == '0) begin
      res_d  = '0;
      flag_d = 1'b1;
    end else if (!neg_s[QB]) begin
      if (ovf_s[QB] || (quo > 33'h0_7FFF_FFFF)) begin
        res_d  = QMAX;
        flag_d = 1'b1;
      end else begin
        res_d = quo[31:0];
      end
    end else begin
      if (ovf_s[QB] || (quo > 33'h0_8000_0000)) begin
        res_d  = QMIN;
        flag_d = 1'b1;
      end else begin
        res_d = ~quo[31:0] + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o_q <= 1'b0;
    end else if (en_i) begin
      vld_o_q <= vld_s[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q   <= res_d;
      flag_q  <= flag_d;
      pay_o_q <= pay_s[QB];
    end
  end

  assign valid_o = vld_o_q;
  assign res_o   = res_q;
  assign flag_o  = flag_q;
  assign pay_o   = pay_o_q;

endmodule
`default_nettype wire

// ----- rtl/cubic_hermite_basis_eval_unit.sv -----
// Top level of the cubic Hermite basis evaluator with derivatives.
`timescale 1ns / 1ps
`default_nettype none
// Each accepted knot u is expanded into four result transactions, basis functions
// h00, h01, h10, h11 in that order, each carrying the value and the first three
// derivatives with respect to u in signed fixed point with FRAC_BITS fraction bits.
// The result channel moves one transaction per cycle while out_ready_i is high, so a
// new knot is taken as the last slot of the previous one issues; the input register
// issues one basis slot per cycle while the pipeline advances, into a fully pipelined
// datapath with four 36-stage restoring dividers in series (t, then up to three
// divisions by the interval length). The whole pipeline holds while a result waits
// at the output. Write interval_start and interval_end only while no knot is in flight.
module cubic_hermite_basis_eval_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  chb_pkg::cfg_idx_t   cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  knot_value_i,
  input  logic                final_knot_in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output chb_pkg::basis_idx_t basis_index_o,
  output logic signed [31:0]  basis_value_o,
  output logic signed [31:0]  first_deriv_o,
  output logic signed [31:0]  second_deriv_o,
  output logic signed [31:0]  third_deriv_o,
  output logic                last_of_knot_o,
  output logic                final_knot_out_o,
  output logic                saturated_o
);
  import chb_pkg::*;

  // Configuration.
  logic signed [31:0] a_q, b_q;
  logic signed [32:0] h;
  logic [32:0]        hmag;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= 32'(64'd1 << FRAC_BITS);
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_START: a_q <= cfg_data_i;
        CFG_END:   b_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  assign h    = {b_q[31], b_q} - {a_q[31], a_q};
  assign hmag = h[32] ? (~h + 33'd1) : h;

  // Pipeline advances unless a result waits at the output.
  logic adv;
  logic out_vld_q;
  assign adv = !out_vld_q || out_ready_i;

  // Slot issue: one basis slot per cycle for the held knot while the pipeline advances.
  logic               busy_q;
  basis_idx_t         cnt_q;
  logic signed [31:0] u_q;
  logic               fin_q;
  logic               in_acc;

  assign in_ready_o = adv && (!busy_q || (cnt_q == LAST_BASIS));
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (adv) begin
      if (in_acc) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == LAST_BASIS) busy_q <= 1'b0;
        cnt_q <= cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      u_q   <= knot_value_i;
      fin_q <= final_knot_in_i;
    end
  end

  // Offset from interval start.
  logic               e_vld_q;
  logic signed [32:0] e_d_q;
  basis_idx_t         e_k_q;
  logic               e_fin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (adv) begin
      e_vld_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_d_q   <= {u_q[31], u_q} - {a_q[31], a_q};
      e_k_q   <= cnt_q;
      e_fin_q <= fin_q;
    end
  end

  // t = d / h.
  logic               t_vld;
  logic signed [31:0] t_res;
  logic               t_flag;
  logic [2:0]         t_pay;

  chb_div #(.FRAC_BITS(FRAC_BITS), .XW(33), .PW(3)) u_div_t (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(e_vld_q), .x_i(e_d_q), .byp_i(1'b0),
    .den_i(hmag), .den_neg_i(h[32]), .pay_i({e_k_q, e_fin_q}),
    .valid_o(t_vld), .res_o(t_res), .flag_o(t_flag), .pay_o(t_pay)
  );

  // t^2.
  logic               s2_vld;
  logic signed [31:0] s2_res;
  logic               s2_flag;
  logic [35:0]        s2_pay;

  chb_mul #(.FRAC_BITS(FRAC_BITS), .YW(32), .PW(36)) u_mul_t2 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(t_vld), .x_i(t_res), .y_i(t_res),
    .byp_i(1'b0), .pay_i({t_res, t_pay, t_flag}),
    .valid_o(s2_vld), .res_o(s2_res), .flag_o(s2_flag), .pay_o(s2_pay)
  );

  // t^3.
  logic               s3_vld;
  logic signed [31:0] s3_res;
  logic               s3_flag;
  logic [67:0]        s3_pay;

  chb_mul #(.FRAC_BITS(FRAC_BITS), .YW(32), .PW(68)) u_mul_t3 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(s2_vld), .x_i(s2_res), .y_i(s2_pay[35:4]),
    .byp_i(1'b0), .pay_i({s2_res, s2_pay[35:1], s2_pay[0] | s2_flag}),
    .valid_o(s3_vld), .res_o(s3_res), .flag_o(s3_flag), .pay_o(s3_pay)
  );

  // Polynomial terms, then exact sum and clip.
  logic signed [31:0] s3_t2, s3_t;
  basis_idx_t         s3_k;
  logic               s3_fin;
  logic               s3_ft;

  assign s3_t2  = s3_pay[67:36];
  assign s3_t   = s3_pay[35:4];
  assign s3_k   = s3_pay[3:2];
  assign s3_fin = s3_pay[1];
  assign s3_ft  = s3_pay[0] | s3_flag;

  logic               p_vld_q;
  logic signed [36:0] p1_q [4];
  logic signed [36:0] p2_q [4];
  logic signed [36:0] p3_q [4];
  logic signed [4:0]  c0_q [4];
  basis_idx_t         p_k_q;
  logic               p_fin_q, p_ft_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (adv) begin
      p_vld_q <= s3_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        p1_q[r] <= 37'(COEF[s3_k][r][1]) * 37'(s3_t);
        p2_q[r] <= 37'(COEF[s3_k][r][2]) * 37'(s3_t2);
        p3_q[r] <= 37'(COEF[s3_k][r][3]) * 37'(s3_res);
        c0_q[r] <= COEF[s3_k][r][0];
      end
      p_k_q   <= s3_k;
      p_fin_q <= s3_fin;
      p_ft_q  <= s3_ft;
    end
  end

  logic signed [39:0] psum [4];
  logic signed [31:0] v_d  [4];
  logic               vflag_d;

  always_comb begin
    vflag_d = p_ft_q;
    for (int r = 0; r < 4; r++) begin
      psum[r] = (40'(c0_q[r]) <<< FRAC_BITS) + 40'(p1_q[r]) + 40'(p2_q[r]) + 40'(p3_q[r]);
      if (psum[r] > 40'(QMAX)) begin
        v_d[r]  = QMAX;
        vflag_d = 1'b1;
      end else if (psum[r] < 40'(QMIN)) begin
        v_d[r]  = QMIN;
        vflag_d = 1'b1;
      end else begin
        v_d[r] = psum[r][31:0];
      end
    end
  end

  logic               v_vld_q;
  logic signed [31:0] v_q [4];
  basis_idx_t         v_k_q;
  logic               v_fin_q, v_flag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_vld_q <= 1'b0;
    end else if (adv) begin
      v_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) v_q[r] <= v_d[r];
      v_k_q    <= p_k_q;
      v_fin_q  <= p_fin_q;
      v_flag_q <= vflag_d;
    end
  end

  // Slope-type value: scale by h.
  logic               m_vld;
  logic signed [31:0] m_res;
  logic               m_flag;
  logic [99:0]        m_pay;

  chb_mul #(.FRAC_BITS(FRAC_BITS), .YW(33), .PW(100)) u_mul_h (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v_vld_q), .x_i(v_q[0]), .y_i(h),
    .byp_i(!v_k_q[1]), .pay_i({v_q[1], v_q[2], v_q[3], v_k_q, v_fin_q, v_flag_q}),
    .valid_o(m_vld), .res_o(m_res), .flag_o(m_flag), .pay_o(m_pay)
  );

  logic               m_byp;
  assign m_byp = m_pay[3];  // slope-type slots skip the first division level

  // First division level.
  logic               l1_vld [3];
  logic signed [31:0] l1_res [3];
  logic               l1_flag [3];
  logic [33:0]        l1a_pay;
  logic [0:0]         l1b_pay, l1c_pay;

  chb_div #(.FRAC_BITS(FRAC_BITS), .XW(32), .PW(34)) u_div_l1a (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(m_vld), .x_i(m_pay[99:68]), .byp_i(m_byp),
    .den_i(hmag), .den_neg_i(h[32]), .pay_i({m_res, m_pay[3:2]}),
    .valid_o(l1_vld[0]), .res_o(l1_res[0]), .flag_o(l1_flag[0]), .pay_o(l1a_pay)
  );

  chb_div #(.FRAC_BITS(FRAC_BITS), .XW(32), .PW(1)) u_div_l1b (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(m_vld), .x_i(m_pay[67:36]), .byp_i(m_byp),
    .den_i(hmag), .den_neg_i(h[32]), .pay_i(m_pay[1]),
    .valid_o(l1_vld[1]), .res_o(l1_res[1]), .flag_o(l1_flag[1]), .pay_o(l1b_pay)
  );

  chb_div #(.FRAC_BITS(FRAC_BITS), .XW(32), .PW(1)) u_div_l1c (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(m_vld), .x_i(m_pay[35:4]), .byp_i(m_byp),
    .den_i(hmag), .den_neg_i(h[32]), .pay_i(m_pay[0] | m_flag),
    .valid_o(l1_vld[2]), .res_o(l1_res[2]), .flag_o(l1_flag[2]), .pay_o(l1c_pay)
  );

  logic l1_valid, l1_fl;
  assign l1_valid = l1_vld[0] & l1_vld[1] & l1_vld[2];
  assign l1_fl    = l1c_pay[0] | l1_flag[0] | l1_flag[1] | l1_flag[2];

  // Second division level.
  logic               l2_vld [2];
  logic signed [31:0] l2_res [2];
  logic               l2_flag [2];
  logic [66:0]        l2a_pay;
  logic [0:0]         l2b_pay;

  chb_div #(.FRAC_BITS(FRAC_BITS), .XW(32), .PW(67)) u_div_l2a (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(l1_valid), .x_i(l1_res[1]), .byp_i(1'b0),
    .den_i(hmag), .den_neg_i(h[32]),
    .pay_i({l1a_pay[33:2], l1_res[0], l1a_pay[1:0], l1_fl}),
    .valid_o(l2_vld[0]), .res_o(l2_res[0]), .flag_o(l2_flag[0]), .pay_o(l2a_pay)
  );

  chb_div #(.FRAC_BITS(FRAC_BITS), .XW(32), .PW(1)) u_div_l2b (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(l1_valid), .x_i(l1_res[2]), .byp_i(1'b0),
    .den_i(hmag), .den_neg_i(h[32]), .pay_i(l1b_pay),
    .valid_o(l2_vld[1]), .res_o(l2_res[1]), .flag_o(l2_flag[1]), .pay_o(l2b_pay)
  );

  logic l2_valid;
  assign l2_valid = l2_vld[0] & l2_vld[1];

  // Third division level, third derivative only.
  logic               l3_vld;
  logic signed [31:0] l3_res;
  logic               l3_flag;
  logic [99:0]        l3_pay;

  chb_div #(.FRAC_BITS(FRAC_BITS), .XW(32), .PW(100)) u_div_l3 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(l2_valid), .x_i(l2_res[1]), .byp_i(1'b0),
    .den_i(hmag), .den_neg_i(h[32]),
    .pay_i({l2a_pay[66:3], l2_res[0], l2a_pay[2:1], l2b_pay[0],
            l2a_pay[0] | l2_flag[0] | l2_flag[1]}),
    .valid_o(l3_vld), .res_o(l3_res), .flag_o(l3_flag), .pay_o(l3_pay)
  );

  // Output register.
  basis_idx_t         o_k_q;
  logic signed [31:0] o_v0_q, o_v1_q, o_v2_q, o_v3_q;
  logic               o_fin_q, o_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= l3_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_v0_q  <= l3_pay[99:68];
      o_v1_q  <= l3_pay[67:36];
      o_v2_q  <= l3_pay[35:4];
      o_v3_q  <= l3_res;
      o_k_q   <= l3_pay[3:2];
      o_fin_q <= l3_pay[1];
      o_sat_q <= l3_pay[0] | l3_flag;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign basis_index_o    = o_k_q;
  assign basis_value_o    = o_v0_q;
  assign first_deriv_o    = o_v1_q;
  assign second_deriv_o   = o_v2_q;
  assign third_deriv_o    = o_v3_q;
  assign last_of_knot_o   = (o_k_q == LAST_BASIS);
  assign final_knot_out_o = o_fin_q;
  assign saturated_o      = o_sat_q;

endmodule
`default_nettype wire

// ----- rtl/chb_checker.sv -----
// Port-level checks for the cubic Hermite basis evaluator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module chb_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire chb_pkg::basis_idx_t basis_index_o,
  input wire logic [31:0]         basis_value_o,
  input wire logic                last_of_knot_o,
  input wire logic                saturated_o
);
  import chb_pkg::*;

  logic       out_acc, in_acc;
  basis_idx_t exp_q;
  logic [7:0] pend_q;

  assign out_acc = out_valid_o && out_ready_i;
  assign in_acc  = in_valid_i && in_ready_o;

  // Track the expected basis index and the knots still owed results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q  <= '0;
      pend_q <= '0;
    end else begin
      if (out_acc) exp_q <= basis_index_o + 2'd1;
      pend_q <= pend_q + {7'd0, in_acc} - {7'd0, out_acc && last_of_knot_o};
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(basis_value_o)
      && $stable(basis_index_o) && $stable(saturated_o))
    else $error("result changed while stalled");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> basis_index_o == exp_q)
    else $error("basis results out of order");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> last_of_knot_o == (basis_index_o == LAST_BASIS))
    else $error("last marker not on final basis");

  a_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && last_of_knot_o |-> pend_q != 8'd0)
    else $error("knot completed that was never accepted");

endmodule

bind cubic_hermite_basis_eval_unit chb_checker u_chb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .basis_index_o  (basis_index_o),
  .basis_value_o  (basis_value_o),
  .last_of_knot_o (last_of_knot_o),
  .saturated_o    (saturated_o)
);
`default_nettype wire
